FILE: design/mwbm_pkg.sv
package mwbm_pkg;

  localparam int NODES    = 32;
  localparam int IDX_W    = 5;
  localparam int SIZE_W   = 6;
  localparam int WGT_W    = 16;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int CFG_A_W  = 2;
  localparam int DEF_LABEL_BITS = 24;

  localparam logic [CFG_A_W-1:0] CFG_X_SIZE  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_Y_SIZE  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PERFECT = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_CHK,
    S_INIT_WR,
    S_TSTART,
    S_POP,
    S_SCAN,
    S_SCAN_CHK,
    S_DELTA,
    S_UPD,
    S_AUG,
    S_OUT_RD,
    S_OUT_CHK,
    S_FLUSH,
    S_FAIL
  } state_t;

  // Map a size register onto the usable range 1..NODES.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    if (s == '0) begin
      return SIZE_W'(1);
    end else if (s > SIZE_W'(NODES)) begin
      return SIZE_W'(NODES);
    end
    return s;
  endfunction

endpackage

FILE: design/mwbm_if.sv
interface mwbm_in_if;
  import mwbm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [WGT_W-1:0] weight;
  logic                    last_weight;
  modport source(output valid, row, col, weight, last_weight, input ready);
  modport sink(input valid, row, col, weight, last_weight, output ready);
endinterface

interface mwbm_out_if;
  import mwbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] left_node;
  logic [IDX_W-1:0] right_node;
  logic             pair_valid;
  logic             status;
  logic             last_result;
  modport source(output valid, left_node, right_node, pair_valid, status, last_result,
                 input ready);
  modport sink(input valid, left_node, right_node, pair_valid, status, last_result,
               output ready);
endinterface

interface mwbm_cfg_if;
  import mwbm_pkg::*;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [SIZE_W-1:0]  data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

FILE: design/mwbm_wmem.sv
module mwbm_wmem (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mwbm_pkg::ADDR_W-1:0]       waddr,
  input  logic signed [mwbm_pkg::WGT_W-1:0] wdata,
  input  logic                              re,
  input  logic [mwbm_pkg::ADDR_W-1:0]       raddr,
  output logic signed [mwbm_pkg::WGT_W-1:0] rdata
);
  import mwbm_pkg::*;

  logic signed [WGT_W-1:0] mem [NODES*NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/max_weight_bipartite_matcher_unit.sv
// channel | dir | words                                   | handshake
// in_ch   | in  | row, col, weight, last_weight           | valid/ready
// out_ch  | out | left_node, right_node, pair_valid,      | valid/ready
//         |     | status, last_result                     |
// cfg_ch  | in  | addr (0 x_size, 1 y_size, 2 perfect), data | valid/ready
//
// Weights load one word per cycle into a 1024-entry RAM while idle. The word
// with last_weight starts the solve (n = larger size): label setup takes the
// row maxima floored at zero, then per left node and label round the search
// pops nodes from its queue and scans their rows, finds the step, moves the
// labels and augments; the RAM read and the shared slack adder set this pace.
// Each result waits on a RAM read; a stalled output holds the sequencer.
// Reset is synchronous and clears control only.
module max_weight_bipartite_matcher_unit #(
  parameter int LABEL_BITS = mwbm_pkg::DEF_LABEL_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  mwbm_in_if.sink    in_ch,
  mwbm_out_if.source out_ch,
  mwbm_cfg_if.sink   cfg_ch
);
  import mwbm_pkg::*;

  localparam int SW = ((LABEL_BITS > WGT_W) ? LABEL_BITS : WGT_W) + 2;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] xs_r, ys_r;
  logic              pm_r;
  logic [SIZE_W-1:0] xs_c, ys_c, n_c;

  logic [SIZE_W-1:0] i_r, j_r, t_r, qh_r, qt_r, step_r;
  logic [IDX_W-1:0]  cx_r, y_r;
  logic signed [WGT_W-1:0] best_r;
  logic signed [SW-1:0]    delta_r;
  logic              have_r;

  logic signed [LABEL_BITS-1:0] ll_r [NODES];
  logic signed [LABEL_BITS-1:0] rl_r [NODES];
  logic [IDX_W-1:0]  lm_r [NODES];
  logic [IDX_W-1:0]  rm_r [NODES];
  logic [IDX_W-1:0]  par_r [NODES];
  logic [IDX_W-1:0]  q_r [NODES];
  logic signed [SW-1:0] ms_r [NODES];
  logic [NODES-1:0]  lhas_r, rhas_r, lv_r, rv_r, inf_r;

  logic              pend_r;
  logic [IDX_W-1:0]  pend_l_r, pend_rt_r;

  logic              ov_r, o_pv_r, o_st_r, o_last_r;
  logic [IDX_W-1:0]  o_l_r, o_rt_r;

  logic              in_acc, out_busy;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic signed [WGT_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_row_r, rd_col_r;

  logic [IDX_W-1:0]  ix, jx;
  logic              inb, neg, ne;
  logic signed [WGT_W-1:0] eff;
  logic signed [SW-1:0]    slack, ll_dn, rl_up;
  logic              slack_zero, qualify, out_stall, aug_done;
  logic [IDX_W-1:0]  ax;

  logic              out_load, o_pv_nxt, o_st_nxt, o_last_nxt;
  logic [IDX_W-1:0]  o_l_nxt, o_rt_nxt;

  assign xs_c = clamp_size(xs_r);
  assign ys_c = clamp_size(ys_r);
  assign n_c  = (xs_c > ys_c) ? xs_c : ys_c;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_busy = ov_r && !out_ch.ready;
  assign ix = i_r[IDX_W-1:0];
  assign jx = j_r[IDX_W-1:0];

  mwbm_wmem u_wmem (
    .clk   (clk),
    .we    (in_acc),
    .waddr ({in_ch.row, in_ch.col}),
    .wdata (in_ch.weight),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Effective weight: zero outside the area, or if negative and not perfect.
  assign inb = ({1'b0, rd_row_r} < xs_c) && ({1'b0, rd_col_r} < ys_c);
  assign neg = !pm_r && rd_data[WGT_W-1];
  assign ne  = inb && neg;
  assign eff = (inb && !neg) ? rd_data : '0;

  assign slack = SW'(ll_r[cx_r]) + SW'(rl_r[jx]) - SW'(eff);
  assign slack_zero = (slack == '0);
  assign ll_dn = SW'(ll_r[jx]) - delta_r;
  assign rl_up = SW'(rl_r[jx]) + delta_r;

  assign qualify   = lhas_r[ix] && ({1'b0, lm_r[ix]} < ys_c) && !ne;
  assign out_stall = qualify && pend_r && out_busy;
  assign ax        = par_r[y_r];
  assign aug_done  = !lhas_r[ax] || (step_r == n_c);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_acc && in_ch.last_weight) state_nxt = S_INIT_RD;
      S_INIT_RD:  state_nxt = S_INIT_CHK;
      S_INIT_CHK: state_nxt = (j_r == n_c - 1'b1) ? S_INIT_WR : S_INIT_RD;
      S_INIT_WR:  state_nxt = (i_r == n_c - 1'b1) ? S_TSTART : S_INIT_RD;
      S_TSTART:   state_nxt = S_POP;
      S_POP:      state_nxt = (qh_r < qt_r) ? S_SCAN : S_DELTA;
      S_SCAN: begin
        if (j_r == n_c) begin
          state_nxt = S_POP;
        end else if (!rv_r[jx]) begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: state_nxt = (slack_zero && !rhas_r[jx]) ? S_AUG : S_SCAN;
      S_DELTA: begin
        if (j_r == n_c) begin
          state_nxt = (!have_r || delta_r[SW-1] || delta_r == '0) ? S_FAIL : S_UPD;
        end
      end
      S_UPD: begin
        if (j_r == n_c) begin
          state_nxt = (t_r == n_c - 1'b1) ? S_FAIL : S_TSTART;
        end
      end
      S_AUG: begin
        if (aug_done) begin
          state_nxt = (i_r == n_c - 1'b1) ? S_OUT_RD : S_TSTART;
        end
      end
      S_OUT_RD:  state_nxt = (i_r == xs_c) ? S_FLUSH : S_OUT_CHK;
      S_OUT_CHK: if (!out_stall) state_nxt = S_OUT_RD;
      S_FLUSH:   if (!out_busy) state_nxt = S_IDLE;
      S_FAIL:    if (!out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = {ix, jx};
    out_load   = 1'b0;
    o_l_nxt    = '0;
    o_rt_nxt   = '0;
    o_pv_nxt   = 1'b0;
    o_st_nxt   = 1'b0;
    o_last_nxt = 1'b1;
    case (state_r)
      S_INIT_RD: mem_re = 1'b1;
      S_SCAN: begin
        mem_re    = (j_r != n_c) && !rv_r[jx];
        mem_raddr = {cx_r, jx};
      end
      S_OUT_RD: begin
        mem_re    = (i_r != xs_c);
        mem_raddr = {ix, lm_r[ix]};
      end
      S_OUT_CHK: begin
        out_load   = qualify && pend_r && !out_busy;
        o_l_nxt    = pend_l_r;
        o_rt_nxt   = pend_rt_r;
        o_pv_nxt   = 1'b1;
        o_last_nxt = 1'b0;
      end
      S_FLUSH: begin
        out_load = !out_busy;
        o_l_nxt  = pend_r ? pend_l_r : '0;
        o_rt_nxt = pend_r ? pend_rt_r : '0;
        o_pv_nxt = pend_r;
      end
      S_FAIL: begin
        out_load = !out_busy;
        o_st_nxt = 1'b1;
      end
      default: mem_re = 1'b0;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      xs_r    <= SIZE_W'(NODES);
      ys_r    <= SIZE_W'(NODES);
      pm_r    <= 1'b1;
      ov_r    <= 1'b0;
      qh_r    <= '0;
      qt_r    <= '0;
      lhas_r  <= '0;
      rhas_r  <= '0;
      lv_r    <= '0;
      rv_r    <= '0;
      inf_r   <= '1;
      pend_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          CFG_X_SIZE:  xs_r <= cfg_ch.data;
          CFG_Y_SIZE:  ys_r <= cfg_ch.data;
          CFG_PERFECT: pm_r <= cfg_ch.data[0];
          default:     pm_r <= pm_r;
        endcase
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.last_weight) begin
            lhas_r <= '0;
            rhas_r <= '0;
          end
        end
        S_TSTART: begin
          // only the root starts visited
          lv_r  <= NODES'(1) << ix;
          rv_r  <= '0;
          inf_r <= '1;
          qh_r  <= '0;
          qt_r  <= SIZE_W'(1);
        end
        S_POP: begin
          if (qh_r < qt_r) begin
            qh_r <= qh_r + 1'b1;
          end
        end
        S_SCAN_CHK: begin
          if (slack_zero) begin
            rv_r[jx] <= 1'b1;
            if (rhas_r[jx]) begin
              if (qt_r < SIZE_W'(NODES)) begin
                qt_r <= qt_r + 1'b1;
              end
              lv_r[rm_r[jx]] <= 1'b1;
            end
          end else if (inf_r[jx] || slack < ms_r[jx]) begin
            inf_r[jx] <= 1'b0;
          end
        end
        S_DELTA: begin
          if (j_r != n_c && !rv_r[jx] && !inf_r[jx] && (!have_r || ms_r[jx] < delta_r)) begin
            have_r <= 1'b1;
          end
        end
        S_AUG: begin
          rhas_r[y_r] <= 1'b1;
          lhas_r[ax]  <= 1'b1;
        end
        S_OUT_RD: begin
          if (i_r == xs_c) begin
            pend_r <= pend_r;
          end
        end
        S_OUT_CHK: begin
          if (qualify && !out_stall) begin
            pend_r <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (!out_busy) begin
            pend_r <= 1'b0;
          end
        end
        default: have_r <= have_r;
      endcase
      if (state_r == S_POP && !(qh_r < qt_r)) begin
        have_r <= 1'b0;
      end
      if (state_r == S_AUG && aug_done && i_r == n_c - 1'b1) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Datapath: counters, tables and the output word.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_row_r <= mem_raddr[ADDR_W-1:IDX_W];
      rd_col_r <= mem_raddr[IDX_W-1:0];
    end
    if (out_load) begin
      o_l_r    <= o_l_nxt;
      o_rt_r   <= o_rt_nxt;
      o_pv_r   <= o_pv_nxt;
      o_st_r   <= o_st_nxt;
      o_last_r <= o_last_nxt;
    end
    case (state_r)
      S_IDLE: begin
        i_r    <= '0;
        j_r    <= '0;
        best_r <= '0;
      end
      S_INIT_CHK: begin
        if (eff > best_r) begin
          best_r <= eff;
        end
        j_r <= j_r + 1'b1;
      end
      S_INIT_WR: begin
        ll_r[ix] <= LABEL_BITS'(SW'(best_r));
        rl_r[ix] <= '0;
        best_r   <= '0;
        j_r      <= '0;
        i_r      <= (i_r == n_c - 1'b1) ? '0 : i_r + 1'b1;
        t_r      <= '0;
      end
      S_TSTART: begin
        q_r[0] <= ix;
      end
      S_POP: begin
        cx_r    <= q_r[qh_r[IDX_W-1:0]];
        j_r     <= '0;
        delta_r <= '0;
      end
      S_SCAN: begin
        if (j_r != n_c && rv_r[jx]) begin
          j_r <= j_r + 1'b1;
        end
      end
      S_SCAN_CHK: begin
        j_r <= j_r + 1'b1;
        if (slack_zero) begin
          par_r[jx] <= cx_r;
          y_r       <= jx;
          step_r    <= '0;
          if (rhas_r[jx] && qt_r < SIZE_W'(NODES)) begin
            q_r[qt_r[IDX_W-1:0]] <= rm_r[jx];
          end
        end else if (inf_r[jx] || slack < ms_r[jx]) begin
          ms_r[jx] <= slack;
        end
      end
      S_DELTA: begin
        if (j_r == n_c) begin
          j_r <= '0;
        end else begin
          j_r <= j_r + 1'b1;
          if (!rv_r[jx] && !inf_r[jx] && (!have_r || ms_r[jx] < delta_r)) begin
            delta_r <= ms_r[jx];
          end
        end
      end
      S_UPD: begin
        if (j_r == n_c) begin
          t_r <= t_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
          if (lv_r[jx]) begin
            ll_r[jx] <= ll_dn[LABEL_BITS-1:0];
          end
          if (rv_r[jx]) begin
            rl_r[jx] <= rl_up[LABEL_BITS-1:0];
          end
        end
      end
      S_AUG: begin
        rm_r[y_r] <= ax;
        lm_r[ax]  <= y_r;
        y_r       <= lm_r[ax];
        step_r    <= step_r + 1'b1;
        if (aug_done) begin
          t_r <= '0;
          i_r <= (i_r == n_c - 1'b1) ? '0 : i_r + 1'b1;
        end
      end
      S_OUT_CHK: begin
        if (!out_stall) begin
          i_r <= i_r + 1'b1;
          if (qualify) begin
            pend_l_r  <= ix;
            pend_rt_r <= lm_r[ix];
          end
        end
      end
      default: cx_r <= cx_r;
    endcase
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.left_node   = o_l_r;
  assign out_ch.right_node  = o_rt_r;
  assign out_ch.pair_valid  = o_pv_r;
  assign out_ch.status      = o_st_r;
  assign out_ch.last_result = o_last_r;

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qh_r <= qt_r)
    else $error("queue head passed tail");

  a_step_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (!delta_r[SW-1] && delta_r != '0))
    else $error("label step not positive");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_st_r) |-> (!o_pv_r && o_last_r))
    else $error("failure word carries a pair");

  a_no_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !out_load)
    else $error("output word loaded while idle");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mwbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 10000000;
  localparam int DRAIN_CYCLES   = 50;

  typedef struct packed {
    logic [IDX_W-1:0] left_node;
    logic [IDX_W-1:0] right_node;
    logic             pair_valid;
    logic             status;
    logic             last_result;
  } match_word_t;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  mwbm_in_if  in_ch ();
  mwbm_out_if out_ch ();
  mwbm_cfg_if cfg_ch ();

  max_weight_bipartite_matcher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // matcher shadow state
  logic [SIZE_W-1:0] x_size_reg, y_size_reg;
  logic              perfect_reg;
  longint wt_mem [NODES][NODES];
  longint eff_wt [NODES][NODES];
  bit     no_edge [NODES][NODES];
  int     lmatch [NODES], rmatch [NODES];
  bit     lhas [NODES], rhas [NODES];
  longint llabel [NODES], rlabel [NODES];
  bit     lvis [NODES], rvis [NODES];
  int     parent [NODES];
  longint min_slack [NODES];
  bit     slack_inf [NODES];
  int     bfs_q [NODES];

  match_word_t pending_pairs [$];

  int errors;
  int words_sent;
  int solves;
  int pairs_seen;
  int idle_cycles = 0;
  int tx_idle_pct;
  int rx_stall_pct;

  function automatic longint wrap_label(longint v);
    logic signed [DEF_LABEL_BITS-1:0] t;
    t = v[DEF_LABEL_BITS-1:0];
    return longint'(t);
  endfunction

  function automatic int eff_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > NODES) return NODES;
    return int'(s);
  endfunction

  function automatic void augment_path(int j, int n);
    int y;
    int x;
    int py;
    bit had;
    y = j;
    for (int k = 0; k <= n; k++) begin
      x = parent[y];
      had = lhas[x];
      py = lmatch[x];
      rmatch[y] = x;
      rhas[y] = 1'b1;
      lmatch[x] = y;
      lhas[x] = 1'b1;
      if (!had) break;
      y = py;
    end
  endfunction

  function automatic bit grow_tree(int root, int n);
    int qh;
    int qt;
    int cx;
    int nx;
    longint delta;
    longint slack;
    bit have;
    for (int t = 0; t < n; t++) begin
      qh = 0;
      qt = 0;
      delta = 0;
      have = 1'b0;
      for (int j = 0; j < NODES; j++) begin
        lvis[j] = 1'b0;
        rvis[j] = 1'b0;
        slack_inf[j] = 1'b1;
        min_slack[j] = 0;
        parent[j] = 0;
      end
      lvis[root] = 1'b1;
      bfs_q[qt++] = root;
      while (qh < qt) begin
        cx = bfs_q[qh++];
        for (int j = 0; j < n; j++) begin
          if (rvis[j]) continue;
          slack = llabel[cx] + rlabel[j] - eff_wt[cx][j];
          if (slack == 0) begin
            rvis[j] = 1'b1;
            parent[j] = cx;
            if (!rhas[j]) begin
              augment_path(j, n);
              return 1'b1;
            end
            nx = rmatch[j];
            if (qt < NODES) bfs_q[qt++] = nx;
            lvis[nx] = 1'b1;
          end else if (slack_inf[j] || slack < min_slack[j]) begin
            slack_inf[j] = 1'b0;
            min_slack[j] = slack;
          end
        end
      end
      for (int j = 0; j < n; j++) begin
        if (rvis[j] || slack_inf[j]) continue;
        if (!have || min_slack[j] < delta) begin
          delta = min_slack[j];
          have = 1'b1;
        end
      end
      if (!have || delta <= 0) return 1'b0;
      for (int k = 0; k < n; k++) begin
        if (lvis[k]) llabel[k] = wrap_label(llabel[k] - delta);
        if (rvis[k]) rlabel[k] = wrap_label(rlabel[k] + delta);
      end
    end
    return 1'b0;
  endfunction

  // Solve the loaded matrix and queue the pairs the block must emit.
  function automatic void predict_matching();
    int xs;
    int ys;
    int n;
    int m;
    int cnt;
    longint best;
    longint w;
    match_word_t mw;
    xs = eff_size(x_size_reg);
    ys = eff_size(y_size_reg);
    n = (xs > ys) ? xs : ys;
    for (int i = 0; i < n; i++) begin
      best = 0;
      for (int j = 0; j < n; j++) begin
        w = 0;
        no_edge[i][j] = 1'b0;
        if (i < xs && j < ys) begin
          w = wt_mem[i][j];
          if (!perfect_reg && w < 0) begin
            w = 0;
            no_edge[i][j] = 1'b1;
          end
        end
        eff_wt[i][j] = w;
        if (w > best) best = w;
      end
      llabel[i] = wrap_label(best);
      rlabel[i] = 0;
      lhas[i] = 1'b0;
      rhas[i] = 1'b0;
      lmatch[i] = 0;
      rmatch[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (!grow_tree(i, n)) begin
        mw = '{left_node: '0, right_node: '0, pair_valid: 1'b0, status: 1'b1,
               last_result: 1'b1};
        pending_pairs = {pending_pairs, mw};
        return;
      end
    end
    cnt = 0;
    for (int i = 0; i < xs; i++) begin
      m = lmatch[i];
      if (lhas[i] && m < ys && !no_edge[i][m]) begin
        mw = '{left_node: IDX_W'(i), right_node: IDX_W'(m), pair_valid: 1'b1,
               status: 1'b0, last_result: 1'b0};
        pending_pairs = {pending_pairs, mw};
        cnt++;
      end
    end
    if (cnt == 0) begin
      mw = '{left_node: '0, right_node: '0, pair_valid: 1'b0, status: 1'b0,
             last_result: 1'b1};
      pending_pairs = {pending_pairs, mw};
    end else begin
      pending_pairs[pending_pairs.size()-1].last_result = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Send one weight word; valid stays high for back-to-back words.
  task automatic send_weight(input int row, input int col, input longint w,
                             input bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.row         <= IDX_W'(row);
    in_ch.col         <= IDX_W'(col);
    in_ch.weight      <= WGT_W'(w);
    in_ch.last_weight <= last;
    do @(posedge clk); while (!in_ch.ready);
    wt_mem[row][col] = w;
    words_sent++;
    if (last) begin
      solves++;
      predict_matching();
    end
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= SIZE_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (addr)
      CFG_X_SIZE:  x_size_reg = SIZE_W'(value);
      CFG_Y_SIZE:  y_size_reg = SIZE_W'(value);
      CFG_PERFECT: perfect_reg = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Reconfigure only once the block has drained.
  task automatic set_shape(input int xs, input int ys, input bit perfect);
    end_burst();
    wait (pending_pairs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_X_SIZE, xs);
    write_reg(CFG_Y_SIZE, ys);
    write_reg(CFG_PERFECT, perfect);
  endtask

  function automatic longint pick_weight(int style);
    case (style)
      0: return longint'($urandom_range(40)) - 20;
      1: return longint'($signed(16'($urandom)));
      default: return ($urandom_range(1)) ? 32767 : -32768;
    endcase
  endfunction

  // Write every cell of the active area in shuffled order, last one starts the solve.
  task automatic load_matrix(input int style);
    int cells [$];
    int xs;
    int ys;
    int k;
    int tmp;
    xs = eff_size(x_size_reg);
    ys = eff_size(y_size_reg);
    for (int i = 0; i < xs * ys; i++) cells = {cells, i};
    for (int i = cells.size() - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = cells[i];
      cells[i] = cells[k];
      cells[k] = tmp;
    end
    foreach (cells[i]) begin
      send_weight(cells[i] / ys, cells[i] % ys, pick_weight(style),
                  i == cells.size() - 1);
    end
  endtask

  task automatic test_single_cell();
    set_shape(1, 1, 1'b1);
    send_weight(0, 0, 32767, 1'b1);
    send_weight(0, 0, -32768, 1'b1);
  endtask

  task automatic test_no_edge_clamp();
    set_shape(2, 2, 1'b0);
    send_weight(0, 0, -1, 1'b0);
    send_weight(0, 1, -32768, 1'b0);
    send_weight(1, 0, -5, 1'b0);
    send_weight(1, 1, -7, 1'b1);
    // same matrix kept negative in perfect mode
    set_shape(2, 2, 1'b1);
    send_weight(1, 1, -7, 1'b1);
  endtask

  task automatic test_size_clamp();
    // zero reads as one, oversize reads as the full node count
    set_shape(0, 63, 1'b1);
    load_matrix(2);
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int quota);
    int start;
    start = words_sent;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    while (words_sent - start < quota) begin
      if ($urandom_range(9) == 0) set_shape($urandom_range(2, 1), $urandom_range(12, 6),
                                            $urandom_range(1));
      else set_shape($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(1));
      // stray writes anywhere; the full area gets rewritten below
      repeat ($urandom_range(2)) begin
        send_weight($urandom_range(31), $urandom_range(31), pick_weight(1), 1'b0);
      end
      load_matrix($urandom_range(3) == 0 ? 1 : ($urandom_range(5) == 0 ? 2 : 0));
    end
    end_burst();
  endtask

  // Check every result word against the oldest prediction.
  always @(posedge clk) begin
    match_word_t got;
    match_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.left_node, out_ch.right_node, out_ch.pair_valid, out_ch.status,
              out_ch.last_result};
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected word %p", got));
      end else begin
        exp_w = pending_pairs.pop_front();
        if (got.left_node != exp_w.left_node)
          report_mismatch($sformatf("left_node %0d exp %0d", got.left_node,
                                    exp_w.left_node));
        if (got.right_node != exp_w.right_node)
          report_mismatch($sformatf("right_node %0d exp %0d", got.right_node,
                                    exp_w.right_node));
        if (got.pair_valid != exp_w.pair_valid)
          report_mismatch($sformatf("pair_valid %0b exp %0b", got.pair_valid,
                                    exp_w.pair_valid));
        if (got.status != exp_w.status)
          report_mismatch($sformatf("status %0b exp %0b", got.status, exp_w.status));
        if (got.last_result != exp_w.last_result)
          report_mismatch($sformatf("last_result %0b exp %0b", got.last_result,
                                    exp_w.last_result));
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    solves = 0;
    pairs_seen = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    x_size_reg = SIZE_W'(32);
    y_size_reg = SIZE_W'(32);
    perfect_reg = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.weight = '0;
    in_ch.last_weight = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = CFG_X_SIZE;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_cell();
    test_no_edge_clamp();
    test_size_clamp();
    test_random_phase(7, 84, 30);
    test_random_phase(84, 7, 30);
    test_random_phase(0, 0, 30);

    wait (pending_pairs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d weight words, %0d solves, %0d result words checked.",
             words_sent, solves, pairs_seen);
    $display("Shapes 1x1 to 2x12 plus a clamped 1x32 case, both weight modes, three stall mixes.");
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
